// ----- hw/rtl/sacf_pkg.sv -----
// Package for the segment allocator: widths, codes and the structs shared by
// the interfaces, the table cell and the top level. No dependencies.
`default_nettype none

package sacf_pkg;

  localparam int ADDR_W          = 16;
  localparam int OWNER_W         = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int MAX_SEGMENTS_DEF = 32;

  localparam logic [ADDR_W-1:0] MEM_TOTAL_RST = ADDR_W'(2048);

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_TOTAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = CFG_IDX_W'(1);

  // fit policy codes, the unused code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_HOLE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_OWNER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_SET    = 3'd1,
    OP_OPEN   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_INIT   = 3'd4
  } cmd_op_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  len;
    logic               busy;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    cmd_op_e op;
    entry_t  ent;
  } cmd_t;

  typedef struct packed {
    logic               is_free;
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  size;
    logic [1:0]         policy;
  } req_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              fit_found;
    logic [ADDR_W-1:0] fit_key;
    logic [ADDR_W-1:0] fit_start;
    logic [ADDR_W-1:0] fit_len;
    logic              own_found;
    logic [ADDR_W-1:0] own_start;
    logic [ADDR_W-1:0] own_len;
    logic              above_free;
    logic [ADDR_W-1:0] above_len;
    logic              below_pend;
    logic              below_free;
    logic [ADDR_W-1:0] below_start;
    logic [ADDR_W-1:0] below_len;
    logic              prev_free;
    logic [ADDR_W-1:0] prev_len;
  } tok_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sacf_if.sv -----
// Handshake interfaces of the segment allocator: request, response and
// configuration write channels. Depends on sacf_pkg.
`default_nettype none

interface sacf_req_if
  import sacf_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [OWNER_W-1:0] owner_id;
  logic [ADDR_W-1:0]  request_size;

  modport source (output valid, output req_type, output owner_id, output request_size,
                  input ready);
  modport sink   (input valid, input req_type, input owner_id, input request_size,
                  output ready);
endinterface

interface sacf_rsp_if
  import sacf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] base_addr;

  modport source (output valid, output status, output base_addr, input ready);
  modport sink   (input valid, input status, input base_addr, output ready);
endinterface

interface sacf_cfg_if
  import sacf_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/segment_allocator_fit_coalesce.sv -----
// Segment allocator, top level: controller, configuration and the chain of
// table cells. Depends on sacf_pkg, sacf_if and sacf_cell.
//
// Keeps an address-ordered table of up to MAX_SEGMENTS segments in a chain of
// cells, entry 0 at the highest addresses. Each request is handled on its own:
// a scan token walks the chain one cell per cycle, a planning step picks the
// hole or released segment, then zero to three table commands split, merge or
// shift the cells, and the result is registered. A new request is taken only
// once the previous one's result is registered, which waits while an earlier
// response is still not accepted. The result register lets the next request
// start while a response waits. Configuration writes are taken only between
// requests; writing memory_total resets the table to one free hole at once.
`default_nettype none

module segment_allocator_fit_coalesce
  import sacf_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input wire         clk_i,
  input wire         rst_ni,
  sacf_req_if.sink   req_i,
  sacf_rsp_if.source rsp_o,
  sacf_cfg_if.sink   cfg_i
);

  localparam int IW    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_PLAN = 5'b00100,
    S_CMD  = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q;
  logic [1:0]        policy_q;
  logic [CNT_W-1:0]  count_q, count_d, plan_count;
  logic [CNT_W-1:0]  scan_cnt_q;
  cmd_t              prog_q [3];
  logic [IW-1:0]     prog_idx_q [3];
  cmd_t              plan_cmd [3];
  logic [IW-1:0]     plan_idx [3];
  logic [1:0]        n_cmd_q, plan_n, step_q;
  status_e           res_status_q, plan_status;
  logic [ADDR_W-1:0] res_addr_q, plan_addr;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_addr_q;

  logic in_acc, cfg_acc, init_wr;
  cmd_t          cell_cmd;
  logic [IW-1:0] cell_idx;

  entry_t        ent  [MAX_SEGMENTS];
  tok_t          tok  [MAX_SEGMENTS];
  logic [IW-1:0] fidx [MAX_SEGMENTS];
  logic [IW-1:0] oidx [MAX_SEGMENTS];
  tok_t          t;
  logic [IW-1:0] fi, oi;
  logic [ADDR_W-1:0] new_start;

  assign cfg_i.ready = (state_q == S_IDLE);
  assign req_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign in_acc  = req_i.valid && req_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign init_wr = cfg_acc && (cfg_i.index == CFG_MEM_TOTAL);

  // command broadcast to all cells
  always_comb begin
    cell_cmd = '{op: OP_NOP, ent: '0};
    cell_idx = '0;
    if (state_q == S_CMD) begin
      cell_cmd = prog_q[step_q];
      cell_idx = prog_idx_q[step_q];
    end else if (init_wr) begin
      cell_cmd.op        = OP_INIT;
      cell_cmd.ent.start = '0;
      cell_cmd.ent.len   = ADDR_W'(cfg_i.data);
      cell_cmd.ent.busy  = 1'b0;
      cell_cmd.ent.owner = '0;
    end
  end

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    entry_t        up_ent, down_ent;
    tok_t          tin;
    logic [IW-1:0] fin, oin;
    if (i == 0) begin : g_first
      assign up_ent = '0;
      assign tin    = '0;
      assign fin    = '0;
      assign oin    = '0;
    end else begin : g_mid
      assign up_ent = ent[i-1];
      assign tin    = tok[i-1];
      assign fin    = fidx[i-1];
      assign oin    = oidx[i-1];
    end
    if (i == MAX_SEGMENTS - 1) begin : g_last
      assign down_ent = '0;
    end else begin : g_notlast
      assign down_ent = ent[i+1];
    end

    sacf_cell #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .IDX          (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .req_i     (req_q),
      .count_i   (count_q),
      .cmd_i     (cell_cmd),
      .cmd_idx_i (cell_idx),
      .up_i      (up_ent),
      .down_i    (down_ent),
      .ent_o     (ent[i]),
      .tok_i     (tin),
      .fit_idx_i (fin),
      .own_idx_i (oin),
      .tok_o     (tok[i]),
      .fit_idx_o (fidx[i]),
      .own_idx_o (oidx[i])
    );
  end

  assign t  = tok[MAX_SEGMENTS-1];
  assign fi = fidx[MAX_SEGMENTS-1];
  assign oi = oidx[MAX_SEGMENTS-1];
  assign new_start = t.fit_start + t.fit_len - req_q.size;

  // decision once the token has left the last cell
  always_comb begin
    plan_n      = 2'd0;
    plan_status = ST_OK;
    plan_addr   = '0;
    plan_count  = count_q;
    for (int k = 0; k < 3; k++) begin
      plan_cmd[k] = '{op: OP_NOP, ent: '0};
      plan_idx[k] = '0;
    end
    if (req_q.is_free == REQ_ALLOC) begin
      if (!t.fit_found) begin
        plan_status = ST_NO_HOLE;
      end else if (t.fit_len == req_q.size) begin
        plan_n      = 2'd1;
        plan_cmd[0] = '{op: OP_SET,
                        ent: '{start: t.fit_start, len: req_q.size, busy: 1'b1,
                               owner: req_q.owner}};
        plan_idx[0] = fi;
        plan_addr   = t.fit_start;
      end else if (count_q == CNT_W'(MAX_SEGMENTS)) begin
        plan_status = ST_FULL;
      end else begin
        plan_n      = 2'd2;
        plan_cmd[0] = '{op: OP_OPEN,
                        ent: '{start: new_start, len: req_q.size, busy: 1'b1,
                               owner: req_q.owner}};
        plan_idx[0] = fi;
        plan_cmd[1] = '{op: OP_SET,
                        ent: '{start: t.fit_start, len: t.fit_len - req_q.size,
                               busy: 1'b0, owner: '0}};
        plan_idx[1] = fi + IW'(1);
        plan_addr   = new_start;
        plan_count  = count_q + CNT_W'(1);
      end
    end else begin
      if (!t.own_found) begin
        plan_status = ST_NO_OWNER;
      end else if (t.above_free && t.below_free) begin
        plan_n      = 2'd3;
        plan_cmd[0] = '{op: OP_SET,
                        ent: '{start: t.below_start,
                               len: t.above_len + t.own_len + t.below_len,
                               busy: 1'b0, owner: '0}};
        plan_idx[0] = oi - IW'(1);
        plan_cmd[1] = '{op: OP_REMOVE, ent: '0};
        plan_idx[1] = oi;
        plan_cmd[2] = '{op: OP_REMOVE, ent: '0};
        plan_idx[2] = oi;
        plan_addr   = t.below_start;
        plan_count  = count_q - CNT_W'(2);
      end else if (t.above_free) begin
        plan_n      = 2'd2;
        plan_cmd[0] = '{op: OP_SET,
                        ent: '{start: t.own_start, len: t.above_len + t.own_len,
                               busy: 1'b0, owner: '0}};
        plan_idx[0] = oi - IW'(1);
        plan_cmd[1] = '{op: OP_REMOVE, ent: '0};
        plan_idx[1] = oi;
        plan_addr   = t.own_start;
        plan_count  = count_q - CNT_W'(1);
      end else if (t.below_free) begin
        plan_n      = 2'd2;
        plan_cmd[0] = '{op: OP_SET,
                        ent: '{start: t.below_start, len: t.below_len + t.own_len,
                               busy: 1'b0, owner: '0}};
        plan_idx[0] = oi + IW'(1);
        plan_cmd[1] = '{op: OP_REMOVE, ent: '0};
        plan_idx[1] = oi;
        plan_addr   = t.below_start;
        plan_count  = count_q - CNT_W'(1);
      end else begin
        plan_n      = 2'd1;
        plan_cmd[0] = '{op: OP_SET,
                        ent: '{start: t.own_start, len: t.own_len, busy: 1'b0,
                               owner: '0}};
        plan_idx[0] = oi;
        plan_addr   = t.own_start;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_SCAN;
        if (init_wr) count_d = CNT_W'(1);
      end
      S_SCAN: begin
        if (scan_cnt_q == CNT_W'(MAX_SEGMENTS - 1)) state_d = S_PLAN;
      end
      S_PLAN: begin
        count_d = plan_count;
        state_d = (plan_n == 2'd0) ? S_RESP : S_CMD;
      end
      S_CMD: begin
        if (step_q == n_cmd_q - 2'd1) state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CNT_W'(1);
      policy_q    <= FIT_FIRST;
      scan_cnt_q  <= '0;
      step_q      <= '0;
      n_cmd_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_acc && (cfg_i.index == CFG_FIT_POLICY)) policy_q <= cfg_i.data[1:0];
      if (in_acc) scan_cnt_q <= '0;
      else if (state_q == S_SCAN) scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      if (state_q == S_PLAN) begin
        n_cmd_q <= plan_n;
        step_q  <= '0;
      end else if (state_q == S_CMD) begin
        step_q <= step_q + 2'd1;
      end
      if (state_q == S_RESP && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.is_free <= req_i.req_type;
      req_q.owner   <= req_i.owner_id;
      req_q.size    <= req_i.request_size;
      req_q.policy  <= policy_q;
    end
    if (state_q == S_PLAN) begin
      prog_q       <= plan_cmd;
      prog_idx_q   <= plan_idx;
      res_status_q <= plan_status;
      res_addr_q   <= plan_addr;
    end
    if (state_q == S_RESP && (!out_valid_q || rsp_o.ready)) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.base_addr = out_addr_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  a_plan_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN) |-> ($past(state_q) == S_SCAN))
    else $error("plan reached without a full scan");

  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_OK)) |-> (out_addr_q == '0))
    else $error("failed request carries an address");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (($past(state_q) == S_PLAN) || $past(init_wr)))
    else $error("segment count changed outside plan or init");

endmodule

`default_nettype wire

// ----- hw/rtl/sacf_cell.sv -----
// One entry of the segment table: holds the segment, updates the scan token
// passing through it and shifts with its neighbours. Depends on sacf_pkg.
`default_nettype none

module sacf_cell
  import sacf_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int IDX          = 0
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  req_t                              req_i,
  input  wire [$clog2(MAX_SEGMENTS+1)-1:0]  count_i,
  input  cmd_t                              cmd_i,
  input  wire [$clog2(MAX_SEGMENTS)-1:0]    cmd_idx_i,
  input  entry_t                            up_i,
  input  entry_t                            down_i,
  output entry_t                            ent_o,
  input  tok_t                              tok_i,
  input  wire [$clog2(MAX_SEGMENTS)-1:0]    fit_idx_i,
  input  wire [$clog2(MAX_SEGMENTS)-1:0]    own_idx_i,
  output tok_t                              tok_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0]   fit_idx_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0]   own_idx_o
);

  localparam int IW    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  entry_t          ent_q, ent_d;
  tok_t            tok_q, tok_d;
  logic [IW-1:0]   fit_idx_q, fit_idx_d, own_idx_q, own_idx_d;
  logic            valid, free_ok, fits, take;
  logic [ADDR_W-1:0] surplus;

  assign valid   = CNT_W'(IDX) < count_i;
  assign free_ok = valid && !ent_q.busy;
  assign fits    = free_ok && (req_i.size != '0) && (ent_q.len >= req_i.size);
  assign surplus = ent_q.len - req_i.size;

  always_comb begin
    if (!tok_i.fit_found) begin
      take = fits;
    end else if (req_i.policy == FIT_BEST) begin
      take = fits && (surplus < tok_i.fit_key);
    end else if (req_i.policy == FIT_WORST) begin
      take = fits && (ent_q.len > tok_i.fit_key);
    end else begin
      take = 1'b0;
    end
  end

  always_comb begin
    tok_d     = tok_i;
    fit_idx_d = fit_idx_i;
    own_idx_d = own_idx_i;
    if (take) begin
      tok_d.fit_found = 1'b1;
      tok_d.fit_key   = (req_i.policy == FIT_WORST) ? ent_q.len : surplus;
      tok_d.fit_start = ent_q.start;
      tok_d.fit_len   = ent_q.len;
      fit_idx_d       = MY_IDX;
    end
    if (!tok_i.own_found && valid && ent_q.busy && (ent_q.owner == req_i.owner)) begin
      tok_d.own_found  = 1'b1;
      tok_d.own_start  = ent_q.start;
      tok_d.own_len    = ent_q.len;
      tok_d.above_free = tok_i.prev_free;
      tok_d.above_len  = tok_i.prev_len;
      tok_d.below_pend = 1'b1;
      own_idx_d        = MY_IDX;
    end else if (tok_i.below_pend) begin
      // neighbour just below the released segment
      tok_d.below_pend  = 1'b0;
      tok_d.below_free  = free_ok;
      tok_d.below_start = ent_q.start;
      tok_d.below_len   = ent_q.len;
    end
    tok_d.prev_free = free_ok;
    tok_d.prev_len  = ent_q.len;
  end

  always_comb begin
    ent_d = ent_q;
    unique case (cmd_i.op)
      OP_SET: begin
        if (MY_IDX == cmd_idx_i) ent_d = cmd_i.ent;
      end
      OP_OPEN: begin
        if (MY_IDX == cmd_idx_i) begin
          ent_d = cmd_i.ent;
        end else if (MY_IDX > cmd_idx_i) begin
          ent_d = up_i;
        end
      end
      OP_REMOVE: begin
        if (MY_IDX >= cmd_idx_i) ent_d = down_i;
      end
      OP_INIT: begin
        if (IDX == 0) ent_d = cmd_i.ent;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.start <= '0;
      ent_q.len   <= (IDX == 0) ? MEM_TOTAL_RST : '0;
      ent_q.busy  <= 1'b0;
      ent_q.owner <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q     <= tok_d;
    fit_idx_q <= fit_idx_d;
    own_idx_q <= own_idx_d;
  end

  assign ent_o     = ent_q;
  assign tok_o     = tok_q;
  assign fit_idx_o = fit_idx_q;
  assign own_idx_o = own_idx_q;

endmodule

`default_nettype wire
